// ----- rtl/bpu_pkg.sv -----
// Shared types and constants for the bitmap pixel unpacker.
// No dependencies; every file but the two channel interfaces imports this package.
package bpu_pkg;

  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int FIFO_DEPTH_DEF    = 4;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_MODE    = 2'd0,
    REG_IMAGE_WIDTH   = 2'd1,
    REG_PALETTE_COUNT = 2'd2
  } reg_index_t;

  // depth_mode codes
  localparam logic [2:0] MODE_1BPP  = 3'd0;
  localparam logic [2:0] MODE_4BPP  = 3'd1;
  localparam logic [2:0] MODE_8BPP  = 3'd2;
  localparam logic [2:0] MODE_16BPP = 3'd3;
  localparam logic [2:0] MODE_24BPP = 3'd4;
  localparam logic [2:0] MODE_32BPP = 3'd5;

  localparam logic [2:0]  DEPTH_MODE_RST    = MODE_8BPP;
  localparam logic [12:0] IMAGE_WIDTH_RST   = 13'd1;
  localparam logic [8:0]  PALETTE_COUNT_RST = 9'd256;

  // item kinds on the input channel
  localparam logic KIND_PAL_WR = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef struct packed {
    logic [2:0]  depth_mode;
    logic [12:0] image_width;
    logic [8:0]  palette_count;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_PAL_WR,
    OP_INDEX,
    OP_DIRECT
  } op_t;

  // One queued job. data: color (PAL_WR), byte in [7:0] (INDEX),
  // {r,g,b,a} (DIRECT). count: pixels to emit for an INDEX job.
  typedef struct packed {
    op_t         op;
    logic [7:0]  addr;
    logic [31:0] data;
    logic [3:0]  count;
    logic        row_end;
  } entry_t;

endpackage

// ----- rtl/bpu_in_if.sv -----
// Input channel: palette writes and pixel data bytes.
// No dependencies.
interface bpu_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  entry_index;
  logic [23:0] entry_color;
  logic [7:0]  data_byte;

  modport source (output valid, kind, entry_index, entry_color, data_byte, input ready);
  modport sink   (input valid, kind, entry_index, entry_color, data_byte, output ready);
endinterface

// ----- rtl/bpu_out_if.sv -----
// Output channel: decoded pixels.
// No dependencies.
interface bpu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       bad_index;
  logic       row_end;
  logic       last;

  modport source (output valid, red, green, blue, alpha, bad_index, row_end, last,
                  input ready);
  modport sink   (input valid, red, green, blue, alpha, bad_index, row_end, last,
                  output ready);
endinterface

// ----- rtl/bpu_front.sv -----
// Front end: accepts items, tracks row position, padding and byte gathering,
// and pushes one job per useful item. Depends on bpu_pkg, bpu_in_if.
module bpu_front #(
  parameter int MAX_WIDTH     = bpu_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  bpu_pkg::cfg_t   cfg,
  bpu_in_if.sink          stream,
  output logic            push,
  output bpu_pkg::entry_t push_entry,
  input  logic            full
);
  import bpu_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WID_W > CFG_W) ? WID_W : CFG_W;

  localparam logic [4:0] FIELD5_MASK = 5'h1f;
  localparam int         RED_SHIFT   = 10;
  localparam int         GREEN_SHIFT = 5;

  logic [23:0]      byte_gather, byte_gather_next;
  logic [1:0]       bytes_in_pixel, bytes_in_pixel_next;
  logic [COL_W-1:0] column, column_next;
  logic [1:0]       row_byte_phase, row_byte_phase_next;
  logic             skipping_pad, skipping_pad_next;

  logic             accept;
  logic [CMP_W-1:0] width_wide;
  logic [WID_W-1:0] eff_width;
  logic [WID_W-1:0] remaining;
  logic             past_end;
  logic [3:0]       per_byte;
  logic [3:0]       step;
  logic             ends;
  logic             palette_mode;
  logic [2:0]       need;
  logic [2:0]       have;
  logic [15:0]      word16;
  logic [7:0]       pr, pg, pb, pa;

  assign stream.ready = !full;
  assign accept       = stream.valid && !full;

  // clamp width into 1..MAX_WIDTH
  always_comb begin
    width_wide = CMP_W'(cfg.image_width);
    if (width_wide == '0) begin
      eff_width = WID_W'(1);
    end else if (width_wide > CMP_W'(MAX_WIDTH)) begin
      eff_width = WID_W'(MAX_WIDTH);
    end else begin
      eff_width = width_wide[WID_W-1:0];
    end
  end

  assign palette_mode = (cfg.depth_mode <= MODE_8BPP);
  // a narrower width written mid-row leaves the column at or past the end:
  // the next pixel then closes the row
  assign past_end     = (WID_W'(column) >= eff_width);
  assign remaining    = eff_width - WID_W'(column);
  assign step         = palette_mode ? per_byte : 4'd1;
  assign ends         = past_end || (remaining <= WID_W'(step));
  assign need         = cfg.depth_mode - 3'd1;
  assign have         = {1'b0, bytes_in_pixel} + 3'd1;
  assign word16       = {stream.data_byte, byte_gather[7:0]};

  always_comb begin
    case (cfg.depth_mode)
      MODE_1BPP: per_byte = 4'd8;
      MODE_4BPP: per_byte = 4'd2;
      default:   per_byte = 4'd1;
    endcase
  end

  // pixel assembly for the direct color modes
  always_comb begin
    pa = 8'd0;
    case (cfg.depth_mode)
      MODE_16BPP: begin
        pr = {3'd0, 5'(word16 >> RED_SHIFT) & FIELD5_MASK};
        pg = {3'd0, 5'(word16 >> GREEN_SHIFT) & FIELD5_MASK};
        pb = {3'd0, word16[4:0] & FIELD5_MASK};
      end
      MODE_24BPP: begin
        pr = stream.data_byte;
        pg = byte_gather[15:8];
        pb = byte_gather[7:0];
      end
      default: begin
        pr = byte_gather[23:16];
        pg = byte_gather[15:8];
        pb = byte_gather[7:0];
        pa = stream.data_byte;
      end
    endcase
  end

  always_comb begin
    byte_gather_next    = byte_gather;
    bytes_in_pixel_next = bytes_in_pixel;
    column_next         = column;
    row_byte_phase_next = row_byte_phase;
    skipping_pad_next   = skipping_pad;
    push                = 1'b0;
    push_entry          = '0;

    if (accept) begin
      if (stream.kind == KIND_PAL_WR) begin
        if ({1'b0, stream.entry_index} < 9'(PALETTE_DEPTH)) begin
          push            = 1'b1;
          push_entry.op   = OP_PAL_WR;
          push_entry.addr = stream.entry_index;
          push_entry.data = {8'd0, stream.entry_color};
        end
      end else if (cfg.depth_mode <= MODE_32BPP) begin
        row_byte_phase_next = row_byte_phase + 2'd1;
        if (skipping_pad) begin
          if (row_byte_phase_next == 2'd0) begin
            skipping_pad_next = 1'b0;
          end
        end else if (palette_mode || have >= need) begin
          push               = 1'b1;
          push_entry.row_end = ends;
          if (palette_mode) begin
            push_entry.op    = OP_INDEX;
            push_entry.data  = {24'd0, stream.data_byte};
            push_entry.count = past_end ? 4'd1 : (ends ? remaining[3:0] : per_byte);
          end else begin
            push_entry.op       = OP_DIRECT;
            push_entry.data     = {pr, pg, pb, pa};
            push_entry.count    = 4'd1;
            bytes_in_pixel_next = 2'd0;
            byte_gather_next    = 24'd0;
          end
          if (ends) begin
            column_next = '0;
            if (row_byte_phase_next != 2'd0) begin
              skipping_pad_next = 1'b1;
            end
          end else begin
            column_next = column + COL_W'(step);
          end
        end else begin
          // still gathering a multi-byte pixel
          case (bytes_in_pixel)
            2'd0:    byte_gather_next[7:0]   = stream.data_byte;
            2'd1:    byte_gather_next[15:8]  = stream.data_byte;
            2'd2:    byte_gather_next[23:16] = stream.data_byte;
            default: byte_gather_next        = byte_gather;
          endcase
          bytes_in_pixel_next = have[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_gather    <= '0;
      bytes_in_pixel <= '0;
      column         <= '0;
      row_byte_phase <= '0;
      skipping_pad   <= 1'b0;
    end else begin
      byte_gather    <= byte_gather_next;
      bytes_in_pixel <= bytes_in_pixel_next;
      column         <= column_next;
      row_byte_phase <= row_byte_phase_next;
      skipping_pad   <= skipping_pad_next;
    end
  end

endmodule

// ----- rtl/bpu_fifo.sv -----
// Short job queue between front and back end.
// Depends on bpu_pkg.
module bpu_fifo #(
  parameter int DEPTH = bpu_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bpu_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output bpu_pkg::entry_t head
);
  import bpu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ----- rtl/bpu_back.sv -----
// Back end: executes jobs, owns the palette memory, expands index bytes
// into pixels and holds the output register. Depends on bpu_pkg, bpu_out_if.
module bpu_back #(
  parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  bpu_pkg::cfg_t   cfg,
  input  logic            head_valid,
  input  bpu_pkg::entry_t head,
  output logic            pop,
  bpu_out_if.source       pixels
);
  import bpu_pkg::*;

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  logic [23:0] palette [PALETTE_DEPTH];
  logic [23:0] rdata;

  logic [2:0]  sub_idx;
  logic [7:0]  pal_idx;
  logic        bad;
  logic        final_pix;
  logic        out_free;
  logic        s1_free;
  logic        s1_adv;
  logic        issue;
  logic        pal_wr;

  // stage 1: palette read in flight
  logic        s1_valid;
  logic        s1_pal;
  logic        s1_bad;
  logic        s1_row_end;
  logic        s1_last;
  logic [31:0] s1_direct;

  assign out_free  = !pixels.valid || pixels.ready;
  assign s1_adv    = s1_valid && out_free;
  assign s1_free   = !s1_valid || out_free;
  assign pal_wr    = head_valid && (head.op == OP_PAL_WR);
  assign issue     = head_valid && (head.op != OP_PAL_WR) && s1_free;
  assign final_pix = (head.op == OP_DIRECT) || ({1'b0, sub_idx} == head.count - 4'd1);
  assign pop       = pal_wr || (issue && final_pix);

  // index k of the byte, most significant first
  always_comb begin
    case (cfg.depth_mode)
      MODE_1BPP: pal_idx = {7'd0, head.data[3'd7 - sub_idx]};
      MODE_4BPP: pal_idx = sub_idx[0] ? {4'd0, head.data[3:0]} : {4'd0, head.data[7:4]};
      default:   pal_idx = head.data[7:0];
    endcase
  end

  assign bad = ({1'b0, pal_idx} >= cfg.palette_count) ||
               ({1'b0, pal_idx} >= 9'(PALETTE_DEPTH));

  always_ff @(posedge clk) begin
    if (pal_wr) begin
      palette[head.addr[PAL_AW-1:0]] <= head.data[23:0];
    end
    if (issue) begin
      rdata <= palette[pal_idx[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_idx      <= '0;
      s1_valid     <= 1'b0;
      pixels.valid <= 1'b0;
    end else begin
      if (issue && head.op == OP_INDEX) begin
        sub_idx <= final_pix ? 3'd0 : sub_idx + 3'd1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        pixels.valid <= 1'b1;
      end else if (pixels.ready) begin
        pixels.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_pal     <= (head.op == OP_INDEX);
      s1_bad     <= bad;
      s1_row_end <= head.row_end && final_pix;
      s1_last    <= final_pix;
      s1_direct  <= head.data;
    end
    if (s1_adv) begin
      pixels.row_end <= s1_row_end;
      pixels.last    <= s1_last;
      if (s1_pal) begin
        pixels.red       <= s1_bad ? 8'd0 : rdata[23:16];
        pixels.green     <= s1_bad ? 8'd0 : rdata[15:8];
        pixels.blue      <= s1_bad ? 8'd0 : rdata[7:0];
        pixels.alpha     <= 8'd0;
        pixels.bad_index <= s1_bad;
      end else begin
        pixels.red       <= s1_direct[31:24];
        pixels.green     <= s1_direct[23:16];
        pixels.blue      <= s1_direct[15:8];
        pixels.alpha     <= s1_direct[7:0];
        pixels.bad_index <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/bmp_pixel_unpacker.sv -----
// Top level of the bitmap pixel unpacker: configuration registers plus
// front end, job queue and back end. Depends on bpu_pkg, bpu_in_if,
// bpu_out_if, bpu_front, bpu_fifo, bpu_back.
//
// Usage:
//  - stream carries one item per valid/ready handshake: a palette write
//    (kind 0) or one pixel data byte in file order (kind 1).
//  - pixels carries decoded pixels; last marks the final pixel of a byte,
//    row_end the final pixel of a row. Padding bytes give no pixel.
//  - cfg_we/cfg_index/cfg_data write depth_mode, image_width and
//    palette_count; write only while the block is idle.
// Timing:
//  - an accepted byte passes the job queue, palette read stage and output
//    register before its first pixel shows; stream takes one item per
//    cycle while the job queue has room; the back end emits one pixel per
//    cycle unless pixels stalls, so a 1 bpp byte holds it for up to 8
//    pixels and a 4 bpp byte for 2; palette writes take no output slot.
//  - when pixels stalls, the output register, the palette read stage and
//    the job queue (FIFO_DEPTH items) fill before stream.ready drops.
// Reset: control state clears, registers go to 8 bpp, width 1, 256
// palette entries. Palette contents are undefined until written.
module bmp_pixel_unpacker #(
  parameter int MAX_WIDTH     = bpu_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_DEPTH = bpu_pkg::PALETTE_DEPTH_DEF,
  parameter int FIFO_DEPTH    = bpu_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bpu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpu_pkg::CFG_W-1:0]      cfg_data,
  bpu_in_if.sink                         stream,
  bpu_out_if.source                      pixels
);
  import bpu_pkg::*;

  cfg_t   cfg;
  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  // configuration registers; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_mode    <= DEPTH_MODE_RST;
      cfg.image_width   <= IMAGE_WIDTH_RST;
      cfg.palette_count <= PALETTE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH_MODE:    cfg.depth_mode    <= cfg_data[2:0];
        REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[12:0];
        REG_PALETTE_COUNT: cfg.palette_count <= cfg_data[8:0];
        default:           cfg               <= cfg;
      endcase
    end
  end

  // front: row position, padding skip, multi-byte gather
  bpu_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .stream     (stream),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  // jobs wait here so palette writes stay ordered with pixel reads
  bpu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: palette memory, index expansion, output register
  bpu_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .pixels     (pixels)
  );

endmodule

// ----- verif/bpu_pixel_check.sv -----
`timescale 1ns / 1ps
// Pixel checker for the bitmap pixel unpacker: tracks register writes, decodes
// every accepted item and compares the pixel stream. Depends on bpu_pkg and both channel interfaces.
module bpu_pixel_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpu_pkg::CFG_W-1:0]     cfg_data,
  bpu_in_if                             stream,
  bpu_out_if                            pixels,
  output int                            mismatches,
  output int                            pending
);
  import bpu_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       bad_index;
    logic       row_end;
    logic       last;
  } pixel_t;

  pixel_t      expected_pixels[$];

  logic [2:0]  depth_mode;
  logic [12:0] image_width;
  logic [8:0]  palette_count;

  logic [23:0] palette[PALETTE_DEPTH_DEF];
  logic [23:0] gather;
  logic [1:0]  gathered;
  logic [12:0] column;
  logic [1:0]  phase;
  logic        skipping;

  // Advance one pixel; true at row end, which arms pad skipping if unaligned.
  function automatic logic step_column();
    logic [12:0] w;
    w = (image_width == 0) ? 13'd1 :
        (image_width > MAX_WIDTH_DEF) ? 13'(MAX_WIDTH_DEF) : image_width;
    column = column + 1'b1;
    if (column >= w) begin
      column = '0;
      if (phase != 0) skipping = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic decode_item(input logic kind, input logic [7:0] slot,
                             input logic [23:0] color, input logic [7:0] data);
    int          bits;
    int          first_new;
    logic [7:0]  pi;
    logic        bad;
    logic        re;
    logic [23:0] c;
    logic [15:0] word;
    pixel_t      px;
    first_new = expected_pixels.size();
    if (kind == KIND_PAL_WR) begin
      palette[slot] = color;
      return;
    end
    if (depth_mode > MODE_32BPP) return;
    phase = phase + 1'b1;
    if (skipping) begin
      if (phase == 0) skipping = 1'b0;
      return;
    end
    if (depth_mode <= MODE_8BPP) begin
      bits = (depth_mode == MODE_1BPP) ? 1 : (depth_mode == MODE_4BPP) ? 4 : 8;
      for (int k = 0; k < 8 / bits; k++) begin
        pi  = 8'((data >> (8 - bits * (k + 1))) & ((1 << bits) - 1));
        bad = {1'b0, pi} >= palette_count;
        c   = bad ? 24'h0 : palette[pi];
        re  = step_column();
        expected_pixels.push_back('{red: c[23:16], green: c[15:8], blue: c[7:0],
                                    alpha: 8'h00, bad_index: bad, row_end: re,
                                    last: 1'b0});
        if (re) break;
      end
    end else begin
      // 16 bpp needs 2 bytes, 24 bpp 3, 32 bpp 4
      if (int'(gathered) + 1 < int'(depth_mode) - 1) begin
        gather[8 * gathered +: 8] = data;
        gathered = gathered + 1'b1;
        return;
      end
      px = '0;
      case (depth_mode)
        MODE_16BPP: begin
          word     = {data, gather[7:0]};
          px.red   = 8'(word[14:10]);
          px.green = 8'(word[9:5]);
          px.blue  = 8'(word[4:0]);
        end
        MODE_24BPP: begin
          px.red   = data;
          px.green = gather[15:8];
          px.blue  = gather[7:0];
        end
        default: begin
          px.red   = gather[23:16];
          px.green = gather[15:8];
          px.blue  = gather[7:0];
          px.alpha = data;
        end
      endcase
      gathered = '0;
      gather   = '0;
      px.row_end = step_column();
      expected_pixels.push_back(px);
    end
    if (expected_pixels.size() > first_new) expected_pixels[$].last = 1'b1;
  endtask

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      depth_mode    = DEPTH_MODE_RST;
      image_width   = IMAGE_WIDTH_RST;
      palette_count = PALETTE_COUNT_RST;
      gather        = '0;
      gathered      = '0;
      column        = '0;
      phase         = '0;
      skipping      = 1'b0;
      mismatches    = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEPTH_MODE:    depth_mode    = cfg_data[2:0];
          REG_IMAGE_WIDTH:   image_width   = cfg_data[12:0];
          REG_PALETTE_COUNT: palette_count = cfg_data[8:0];
          default: ;
        endcase
      end
      if (stream.valid && stream.ready)
        decode_item(stream.kind, stream.entry_index, stream.entry_color, stream.data_byte);
      if (pixels.valid && pixels.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel with no expected pixel waiting");
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, pixels.red);
          check_field("green", want.green, pixels.green);
          check_field("blue", want.blue, pixels.blue);
          check_field("alpha", want.alpha, pixels.alpha);
          check_field("bad_index", want.bad_index, pixels.bad_index);
          check_field("row_end", want.row_end, pixels.row_end);
          check_field("last", want.last, pixels.last);
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ----- verif/tb_bmp_pixel_unpacker.sv -----
`timescale 1ns / 1ps
// Top of the bitmap pixel unpacker testbench: clock, reset, item and register
// stimulus, output stalling and the verdict. Depends on bpu_pkg, the RTL and bpu_pixel_check.
module tb_bmp_pixel_unpacker;
  import bpu_pkg::*;

  // depth codes the block must drop silently
  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  // cycles to let items with no pixel (palette writes, pad bytes) drain
  localparam int SETTLE_CYCLES = 40;
  localparam int FLOOD_CYCLES  = 300;
  localparam int RANDOM_ITEMS  = 70;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bpu_in_if  stream_bus ();
  bpu_out_if pixel_bus ();

  int mismatches;
  int pending;

  // sender state
  int   burst_left;
  logic steady;       // no gaps from the sender in this phase
  logic flood_req;    // asks the receiver for its one long hold-off
  logic [2:0] cur_mode;

  // receiver state
  int   rx_cycles;
  int   hold_left;
  int   stall_style;
  logic flood_done;

  bmp_pixel_unpacker DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stream    (stream_bus),
    .pixels    (pixel_bus)
  );

  bpu_pixel_check pixel_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .stream     (stream_bus),
    .pixels     (pixel_bus),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Receiver: switches among four stall styles at random; holds off once for a
  // long stretch when asked so the job queue fills and the input stalls.
  always @(posedge clk) begin
    if (rst) begin
      pixel_bus.ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 97 == 0) stall_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        pixel_bus.ready <= 1'b0;
      end else if (flood_req && !flood_done) begin
        flood_done = 1'b1;
        hold_left  = FLOOD_CYCLES;
        pixel_bus.ready <= 1'b0;
      end else begin
        case (stall_style)
          0:       pixel_bus.ready <= 1'b1;
          1:       pixel_bus.ready <= 1'($urandom_range(0, 1));
          2:       pixel_bus.ready <= (rx_cycles % 4) != 3;
          default: pixel_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One item on the stream; random gaps open between bursts unless steady.
  // Returns at the edge where the item was taken, valid still high.
  task automatic send_item(input logic kind, input logic [7:0] slot,
                           input logic [23:0] color, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        stream_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    stream_bus.valid       <= 1'b1;
    stream_bus.kind        <= kind;
    stream_bus.entry_index <= slot;
    stream_bus.entry_color <= color;
    stream_bus.data_byte   <= data;
    do @(posedge clk); while (!stream_bus.ready);
  endtask

  // Data byte with noise in the unused payload fields.
  task automatic send_byte(input logic [7:0] data);
    send_item(KIND_DATA, 8'($urandom), 24'($urandom), data);
  endtask

  // Wait for every expected pixel, then some more for items with no pixel.
  task automatic settle();
    stream_bus.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program all three registers on back-to-back edges while idle.
  task automatic program_regs(input logic [2:0] mode, input logic [12:0] width,
                              input logic [8:0] count);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEPTH_MODE;
    cfg_data  <= CFG_W'(mode);
    @(posedge clk);
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= REG_PALETTE_COUNT;
    cfg_data  <= CFG_W'(count);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode = mode;
  endtask

  initial begin
    int          items_sent;
    int          phase_no;
    int          n;
    logic [2:0]  mode;
    logic [12:0] width;
    logic [8:0]  count;

    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= REG_DEPTH_MODE;
    cfg_data               <= '0;
    stream_bus.valid       <= 1'b0;
    stream_bus.kind        <= KIND_DATA;
    stream_bus.entry_index <= '0;
    stream_bus.entry_color <= '0;
    stream_bus.data_byte   <= '0;
    burst_left  = 0;
    steady      = 1'b0;
    flood_req   = 1'b0;
    flood_done  = 1'b0;
    rx_cycles   = 0;
    hold_left   = 0;
    stall_style = 0;
    cur_mode    = MODE_8BPP;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole palette first so no lookup ever hits an unwritten slot.
    // Slot 0 is black, slots 1 and 255 white: color extremes.
    for (int i = 0; i < PALETTE_DEPTH_DEF; i++)
      send_item(KIND_PAL_WR, 8'(i),
                (i == 0) ? 24'h000000 : (i == 1 || i == 255) ? 24'hffffff : 24'($urandom),
                8'($urandom));

    // Reset settings: 8 bpp, one pixel per row, so three pad bytes per row.
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);

    // 1 bpp, width beyond the maximum (clamped), index 1 flagged as bad.
    program_regs(MODE_1BPP, 13'h1fff, 9'd1);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h80);

    // 4 bpp, row of 3 ends mid-byte; empty palette so every index is bad.
    program_regs(MODE_4BPP, 13'd3, 9'd0);
    send_byte(8'h0f);
    send_byte(8'hf0);
    send_byte(8'haa);
    send_byte(8'h55);

    // 16 bpp, width 0 acts as 1, all-ones and all-zero words.
    program_regs(MODE_16BPP, 13'd0, 9'h1ff);
    send_byte(8'hff);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h00);

    // 24 bpp, one pixel per row plus a pad byte.
    program_regs(MODE_24BPP, 13'd1, 9'd256);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
    send_byte(8'h04);

    // 32 bpp, alpha last.
    program_regs(MODE_32BPP, 13'd2, 9'd256);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(8'h44);

    // Unused depth codes drop bytes; palette writes still land.
    program_regs(MODE_UNUSED_LO, 13'd4, 9'd256);
    send_byte(8'h5a);
    send_item(KIND_PAL_WR, 8'h80, 24'h123456, 8'h00);
    program_regs(MODE_UNUSED_HI, 13'd4, 9'd256);
    send_byte(8'ha5);

    // Random phases: fresh settings each time, mostly short rows so row ends
    // and padding come often; a few huge or zero widths; palette counts that
    // make bad indices likely. Phases end at random points, so pixels left
    // half gathered carry across register writes.
    items_sent = 0;
    phase_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      mode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
      case ($urandom_range(0, 15))
        0:       width = 13'd0;
        1:       width = 13'(MAX_WIDTH_DEF);
        2:       width = 13'h1fff;
        3:       width = 13'($urandom_range(1, 8191));
        4:       width = 13'(MAX_WIDTH_DEF - 1);
        default: width = 13'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 7))
        0:       count = 9'd0;
        1:       count = 9'd256;
        2:       count = 9'h1ff;
        3:       count = 9'($urandom_range(0, 511));
        default: count = 9'($urandom_range(0, 300));
      endcase
      n = $urandom_range(15, 50);
      if (phase_no == 0) begin
        // first phase floods the block while the receiver holds off
        mode  = MODE_1BPP;
        width = 13'd8;
        n     = 40;
      end
      program_regs(mode, width, count);
      steady = ($urandom_range(0, 3) == 0);
      if (phase_no == 0) flood_req = 1'b1;
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(KIND_PAL_WR, 8'($urandom), 24'($urandom), 8'($urandom));
          items_sent++;
        end else begin
          send_byte(8'($urandom));
          if (cur_mode <= MODE_32BPP) items_sent++;
        end
      end
      phase_no++;
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("[bmp_pixel_unpacker] OK");
    end else begin
      $display("[bmp_pixel_unpacker] ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("[bmp_pixel_unpacker] ERROR");
    $finish;
  end

endmodule
